// File: rtl/id3fx_pkg.sv
// ----------------------------------------------------------------------------
// ID3v2 frame extractor package
// Shared types and constants: parse phases, frame ids, result kinds.
// ----------------------------------------------------------------------------
package id3fx_pkg;

  // Field selection
  localparam int unsigned FieldCount = 6;
  localparam int unsigned FieldIdW   = 3;
  localparam int unsigned EnableW    = 6;

  localparam logic [FieldIdW-1:0] NO_FIELD           = 3'd7;
  localparam logic [EnableW-1:0]  FIELD_ENABLE_RESET = 6'h3F;

  // Frame ids in field order: TIT2, TALB, TPE1, TPE2, TYER, TRCK
  localparam logic [31:0] FRAME_IDS [FieldCount] = '{
    32'h5449_5432,
    32'h5441_4C42,
    32'h5450_4531,
    32'h5450_4532,
    32'h5459_4552,
    32'h5452_434B
  };

  // Tag header magic "ID3"
  localparam logic [23:0] ID3_MAGIC = 24'h49_44_33;

  // Printable range that ends the leading-byte skip
  localparam logic [7:0] CHAR_LOW  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_HIGH = 8'h5A;  // 'Z'

  // Header byte positions
  localparam logic [3:0] HDR_MAGIC_END = 4'd3;
  localparam logic [3:0] HDR_SIZE_BEG  = 4'd6;
  localparam logic [3:0] HDR_LAST      = 4'd9;
  localparam logic [3:0] FRM_ID_END    = 4'd4;
  localparam logic [3:0] FRM_SIZE_END  = 4'd8;

  // Result kinds
  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_CLEARED = 2'd1;
  localparam logic [1:0] KIND_NO_TAG  = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER    = 2'd0,
    PH_FRAME_HDR = 2'd1,
    PH_BODY      = 2'd2,
    PH_DONE      = 2'd3
  } phase_e;

endpackage

// File: rtl/id3fx_if.sv
// ----------------------------------------------------------------------------
// ID3v2 frame extractor channels
// Valid/ready stream interfaces for file bytes in and field results out.
// ----------------------------------------------------------------------------

// File byte channel
interface id3fx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// Field result channel
interface id3fx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] field_id;
  logic [7:0] value_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output kind, output field_id, output value_byte,
                  output first_byte, output last_byte, input ready);
  modport sink   (input valid, input kind, input field_id, input value_byte,
                  input first_byte, input last_byte, output ready);
endinterface

// File: rtl/id3v2_frame_extractor_unit.sv
// ----------------------------------------------------------------------------
// ID3v2 frame extractor
// Parses the ID3v2.3 tag at the head of a byte stream and emits text fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one file byte per transfer; start_of_file marks byte 0 of a
//   new file and restarts the parse with that byte.
//   out_o carries at most one result per input byte: a value byte of an
//   enabled text field (first/last marked), a cleared-field marker, or a
//   no-tag marker after a bad tag header.
//   cfg_we_i/cfg_wdata_i write the 6-bit field enable mask; write only while
//   the block is idle.
// Timing:
//   One byte per cycle. All parsing for a byte is done between the input
//   transfer and the output register, so a result is valid in the cycle
//   after its byte is taken. Throughput is set by the single
//   output register: one byte a cycle while out_o drains.
// Reset: the parse returns to the tag header phase, the enable mask to all
//   ones and the output register empties.
// Stall: while the output register holds a result that is not taken, in_i
//   is not ready; a byte with no result still needs a free output slot.
// ----------------------------------------------------------------------------
module id3v2_frame_extractor_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  id3fx_in_if.sink            in_i,
  id3fx_out_if.source         out_o,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i
);

  // Parse state
  id3fx_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [3:0]  bp_q, bp_d, cur_bp;
  logic [27:0] tag_q, tag_d, cur_tag, tag_dec;
  logic [31:0] id_q, id_d, cur_id;
  logic [31:0] fr_q, fr_d, cur_fr, fr_dec, fr_clip;
  logic [2:0]  sel_q, sel_d, cur_sel, match_field;
  logic        skip_q, skip_d, cur_skip;
  logic        frame_end;
  logic [5:0]  field_enable_q;

  // Result
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [2:0]  res_field;
  logic [7:0]  res_value;
  logic        res_first;
  logic        res_last;

  logic        accept;
  logic [7:0]  b;

  // Output register
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [2:0]  field_q;
  logic [7:0]  value_q;
  logic        first_q;
  logic        last_q;

  assign b         = in_i.data_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;

  // Restart state for a start-of-file byte
  always_comb begin
    if (in_i.start_of_file) begin
      cur_phase = id3fx_pkg::PH_HEADER;
      cur_bp    = '0;
      cur_tag   = '0;
      cur_id    = '0;
      cur_fr    = '0;
      cur_sel   = id3fx_pkg::NO_FIELD;
      cur_skip  = 1'b1;
    end else begin
      cur_phase = phase_q;
      cur_bp    = bp_q;
      cur_tag   = tag_q;
      cur_id    = id_q;
      cur_fr    = fr_q;
      cur_sel   = sel_q;
      cur_skip  = skip_q;
    end
  end

  // Match the completed frame id against the enabled fields, lowest first
  always_comb begin
    match_field = id3fx_pkg::NO_FIELD;
    for (int k = id3fx_pkg::FieldCount - 1; k >= 0; k--) begin
      if (cur_id == id3fx_pkg::FRAME_IDS[k] && field_enable_q[k]) begin
        match_field = 3'(k);
      end
    end
  end

  assign tag_dec = cur_tag - 28'd1;
  assign fr_dec  = cur_fr - 32'd1;
  assign fr_clip = (cur_fr > {4'b0, tag_dec}) ? {4'b0, tag_dec} : cur_fr;

  // Next state and result for one byte
  always_comb begin
    phase_d   = cur_phase;
    bp_d      = cur_bp;
    tag_d     = cur_tag;
    id_d      = cur_id;
    fr_d      = cur_fr;
    sel_d     = cur_sel;
    skip_d    = cur_skip;
    frame_end = 1'b0;
    res_valid = 1'b0;
    res_kind  = id3fx_pkg::KIND_VALUE;
    res_field = '0;
    res_value = '0;
    res_first = 1'b0;
    res_last  = 1'b0;

    case (cur_phase)
      id3fx_pkg::PH_HEADER: begin
        if (cur_bp < id3fx_pkg::HDR_MAGIC_END) begin
          id_d = {cur_id[23:0], b};
        end else if (cur_bp >= id3fx_pkg::HDR_SIZE_BEG) begin
          tag_d = {cur_tag[20:0], b[6:0]};
        end
        if (cur_bp < id3fx_pkg::HDR_LAST) begin
          bp_d = cur_bp + 4'd1;
        end else if (cur_id[23:0] != id3fx_pkg::ID3_MAGIC) begin
          phase_d   = id3fx_pkg::PH_DONE;
          res_valid = 1'b1;
          res_kind  = id3fx_pkg::KIND_NO_TAG;
        end else begin
          // tag size includes the last size byte taken this cycle
          bp_d    = '0;
          id_d    = '0;
          phase_d = (tag_d != '0) ? id3fx_pkg::PH_FRAME_HDR : id3fx_pkg::PH_DONE;
        end
      end

      id3fx_pkg::PH_FRAME_HDR: begin
        tag_d = tag_dec;
        if (cur_bp == '0 && b == 8'd0) begin
          // padding byte
          if (tag_dec == '0) begin
            phase_d = id3fx_pkg::PH_DONE;
          end
        end else begin
          if (cur_bp < id3fx_pkg::FRM_ID_END) begin
            id_d = {cur_id[23:0], b};
          end else if (cur_bp < id3fx_pkg::FRM_SIZE_END) begin
            fr_d = {cur_fr[23:0], b};
          end
          if (cur_bp < id3fx_pkg::HDR_LAST) begin
            bp_d = cur_bp + 4'd1;
            if (tag_dec == '0) begin
              phase_d = id3fx_pkg::PH_DONE;
            end
          end else begin
            // last header byte: select field and clip the body to the tag
            sel_d  = match_field;
            fr_d   = fr_clip;
            skip_d = 1'b1;
            bp_d   = '0;
            if (fr_clip == '0) begin
              id_d    = '0;
              phase_d = (tag_dec != '0) ? id3fx_pkg::PH_FRAME_HDR : id3fx_pkg::PH_DONE;
              if (match_field != id3fx_pkg::NO_FIELD) begin
                res_valid = 1'b1;
                res_kind  = id3fx_pkg::KIND_CLEARED;
                res_field = match_field;
              end
            end else begin
              phase_d = id3fx_pkg::PH_BODY;
            end
          end
        end
      end

      id3fx_pkg::PH_BODY: begin
        tag_d     = tag_dec;
        fr_d      = fr_dec;
        frame_end = (fr_dec == '0);
        if (frame_end) begin
          bp_d    = '0;
          id_d    = '0;
          phase_d = (tag_dec != '0) ? id3fx_pkg::PH_FRAME_HDR : id3fx_pkg::PH_DONE;
        end
        if (cur_sel != id3fx_pkg::NO_FIELD) begin
          if (cur_skip && (b < id3fx_pkg::CHAR_LOW || b > id3fx_pkg::CHAR_HIGH)) begin
            // drop leading byte; report empty field at frame end
            if (frame_end) begin
              res_valid = 1'b1;
              res_kind  = id3fx_pkg::KIND_CLEARED;
              res_field = cur_sel;
            end
          end else begin
            skip_d    = 1'b0;
            res_valid = 1'b1;
            res_kind  = id3fx_pkg::KIND_VALUE;
            res_field = cur_sel;
            res_value = b;
            res_first = cur_skip;
            res_last  = frame_end;
          end
        end
      end

      default: begin
        // finished: ignore bytes until start of file
      end
    endcase
  end

  // Parse state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= id3fx_pkg::PH_HEADER;
      bp_q    <= '0;
      tag_q   <= '0;
      id_q    <= '0;
      fr_q    <= '0;
      sel_q   <= id3fx_pkg::NO_FIELD;
      skip_q  <= 1'b1;
    end else if (accept) begin
      phase_q <= phase_d;
      bp_q    <= bp_d;
      tag_q   <= tag_d;
      id_q    <= id_d;
      fr_q    <= fr_d;
      sel_q   <= sel_d;
      skip_q  <= skip_d;
    end
  end

  // Field enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_enable_q <= id3fx_pkg::FIELD_ENABLE_RESET;
    end else if (cfg_we_i) begin
      field_enable_q <= cfg_wdata_i;
    end
  end

  // Output valid: load on a result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q  <= res_kind;
      field_q <= res_field;
      value_q <= res_value;
      first_q <= res_first;
      last_q  <= res_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.field_id   = field_q;
  assign out_o.value_byte = value_q;
  assign out_o.first_byte = first_q;
  assign out_o.last_byte  = last_q;

endmodule

// File: rtl/id3fx_checker.sv
// ----------------------------------------------------------------------------
// ID3v2 frame extractor checker
// Port-level assertions on flow control and result encoding.
// ----------------------------------------------------------------------------
module id3fx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [2:0] field_id_i,
  input logic [7:0] value_byte_i,
  input logic       first_byte_i,
  input logic       last_byte_i
);

  // Hold the result while stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(kind_i) && $stable(field_id_i) && $stable(value_byte_i)
       && $stable(first_byte_i) && $stable(last_byte_i)))
    else $error("result changed while stalled");

  // Block new bytes while a result is stalled
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input ready while output register is full");

  // Accept whenever the output register is empty
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready with empty output register");

  // Marker results carry no text and no first/last marks
  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && kind_i != id3fx_pkg::KIND_VALUE) |->
      (value_byte_i == 8'd0 && !first_byte_i && !last_byte_i
       && (kind_i == id3fx_pkg::KIND_CLEARED
           || (kind_i == id3fx_pkg::KIND_NO_TAG && field_id_i == 3'd0))))
    else $error("bad marker result encoding");

  // Field results name a real field
  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && kind_i != id3fx_pkg::KIND_NO_TAG) |-> (field_id_i <= 3'd5))
    else $error("field id out of range");

endmodule

bind id3v2_frame_extractor_unit id3fx_checker u_id3fx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .field_id_i   (out_o.field_id),
  .value_byte_i (out_o.value_byte),
  .first_byte_i (out_o.first_byte),
  .last_byte_i  (out_o.last_byte)
);
